@@ src/bbvp_pkg.sv @@
// Shared types and constants of the basic-block vector profiler.
package bbvp_pkg;

  // Configuration register indexes and their reset values.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgIntervalLength = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgJumpThreshold  = 2'd1;

  localparam logic [31:0] IntervalLengthReset = 32'd1000000;
  localparam logic [15:0] JumpThresholdReset  = 16'd16;

  // Table geometry; block ids on the result port are always six bits.
  localparam int unsigned TableEntriesDefault = 64;
  localparam int unsigned BlockIdW            = 6;
  localparam logic [31:0] CountMax            = 32'hFFFF_FFFF;

  // One input transaction.
  typedef struct packed {
    logic        func;
    logic [63:0] ip;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic                has_entry;
    logic [BlockIdW-1:0] block_id;
    logic [31:0]         count;
    logic                table_full;
    logic                last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic emit;
    logic search;
    logic inc_rd;
    logic inc_wr;
    logic newblk;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wrap;
    logic any_valid;
    logic emit_last;
    logic hit;
    logic miss_done;
  } status_t;

endpackage

@@ src/basic_block_vector_profiler.sv @@
// Top level of the basic-block vector profiler.
//
// Usage: an instruction or flush transaction is taken when start is high and
// busy is low; req_i.func selects a flush. Each result transaction appears on
// res_o for one cycle with res_valid_o high and cannot be held off; the last
// result of a vector carries last, and an empty vector gives a single marker.
// Configuration writes use cfg_valid_i/cfg_ready_o with an index and data and
// must be made only while the block is idle (unenforced); ready is always high.
// Operation: an instruction scans the start-address memory one entry per cycle;
// a hit stops the scan, reads the count and writes it back, and a miss scans
// every used entry and then adds a new block if the jump reaches the threshold
// and the table has room. An emit steps through the table up to the last valid
// entry, with each result in the cycle after its entry is read.
// Reset empties the block table and invalidates every count, without clearing
// the memories; it clears the interval progress, the previous address and the
// full flag, and loads the register defaults.
module basic_block_vector_profiler #(
  parameter int unsigned TableEntries = bbvp_pkg::TableEntriesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bbvp_pkg::in_t                req_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bbvp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output logic                         res_valid_o,
  output bbvp_pkg::out_t               res_o
);
  import bbvp_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  bbvp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (req_i.func),
    .status_i (status),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  bbvp_datapath #(
    .TableEntries (TableEntries)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A result only follows a cycle in which a transaction was in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without a transaction in work");

  // An accepted transaction always makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start work");

  // The last result of a vector is not followed at once by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o)
    else $error("result directly after the last of a vector");

  // An empty-vector marker is always the last result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.has_entry) |-> (res_o.last && res_o.count == 32'd0))
    else $error("empty marker not final or not zero");

endmodule

@@ src/bbvp_ctrl.sv @@
// Controller state machine of the basic-block vector profiler.
module bbvp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              func_i,
  input  bbvp_pkg::status_t status_i,
  output logic              busy,
  output bbvp_pkg::cmd_t    cmd_o
);
  import bbvp_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SEmit   = 3'd1;
  localparam logic [2:0] SSearch = 3'd2;
  localparam logic [2:0] SIncRd  = 3'd3;
  localparam logic [2:0] SIncWr  = 3'd4;
  localparam logic [2:0] SNewBlk = 3'd5;

  logic [2:0] state_q, state_d;
  logic       then_search_q, then_search_d;

  // Next-state and command decode.
  always_comb begin
    state_d       = state_q;
    then_search_d = then_search_q;
    cmd_o         = '0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (func_i) begin
            state_d       = SEmit;
            then_search_d = 1'b0;
          end else if (status_i.wrap) begin
            state_d       = SEmit;
            then_search_d = 1'b1;
          end else begin
            state_d = SSearch;
          end
        end
      end
      SEmit: begin
        cmd_o.emit = 1'b1;
        if (!status_i.any_valid || status_i.emit_last) begin
          state_d = then_search_q ? SSearch : SIdle;
        end
      end
      SSearch: begin
        cmd_o.search = 1'b1;
        if (status_i.hit) begin
          state_d = SIncRd;
        end else if (status_i.miss_done) begin
          state_d = SNewBlk;
        end
      end
      SIncRd: begin
        cmd_o.inc_rd = 1'b1;
        state_d      = SIncWr;
      end
      SIncWr: begin
        cmd_o.inc_wr = 1'b1;
        state_d      = SIdle;
      end
      SNewBlk: begin
        cmd_o.newblk = 1'b1;
        state_d      = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      then_search_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      then_search_q <= then_search_d;
    end
  end

  assign busy = (state_q != SIdle);

endmodule

@@ src/bbvp_datapath.sv @@
// Datapath of the basic-block vector profiler: tables, scan, counters and result register.
module bbvp_datapath #(
  parameter int unsigned TableEntries = bbvp_pkg::TableEntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bbvp_pkg::in_t                  req_i,
  input  bbvp_pkg::cmd_t                 cmd_i,
  output bbvp_pkg::status_t              status_o,
  input  logic                           cfg_valid_i,
  input  logic [bbvp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output logic                           res_valid_o,
  output bbvp_pkg::out_t                 res_o
);
  import bbvp_pkg::*;

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  // Configuration and interval state.
  logic [31:0] interval_len_q;
  logic [15:0] jump_thr_q;
  logic [31:0] progress_q;
  logic [63:0] prev_q;
  logic [63:0] ip_q;
  logic        overflow_q;
  logic [CntW-1:0] used_q;
  logic [TableEntries-1:0] valid_q;

  // Scan and emit pointers.
  logic [IdxW-1:0] eptr_q;
  logic [CntW-1:0] sptr_q;
  logic            cmp_v_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic [63:0]     addr_rd_q;
  logic [IdxW-1:0] hit_idx_q;
  logic            far_q;
  logic [31:0]     cnt_rd_q;

  // Result register.
  logic            res_valid_q;
  logic            res_has_q;
  logic [IdxW-1:0] res_id_q;
  logic            res_full_q;
  logic            res_last_q;

  // Start-address and count memories.
  logic [63:0] addr_mem [TableEntries];
  logic [31:0] cnt_mem  [TableEntries];

  logic                    wrap;
  logic                    any_valid;
  logic                    emit_last;
  logic [TableEntries-1:0] eptr_onehot;
  logic                    scan_more;
  logic                    room;
  logic                    add_block;
  logic [IdxW-1:0]         sptr_idx;
  logic [IdxW-1:0]         used_idx;
  logic [IdxW-1:0]         cnt_raddr;
  logic [31:0]             inc_val;
  logic [64:0]             ip_ext;
  logic [64:0]             prev_ext;
  logic [64:0]             thr_ext;
  logic                    far_d;

  // Interval end test and emit bookkeeping.
  assign wrap        = ({1'b0, progress_q} + 33'd1) >= {1'b0, interval_len_q};
  assign any_valid   = |valid_q;
  assign eptr_onehot = TableEntries'(1) << eptr_q;
  assign emit_last   = (valid_q & ~eptr_onehot) == '0;

  // Scan and new-block decisions.
  assign sptr_idx  = sptr_q[IdxW-1:0];
  assign used_idx  = used_q[IdxW-1:0];
  assign scan_more = sptr_q < used_q;
  assign room      = used_q < CntW'(TableEntries);
  assign add_block = cmd_i.newblk && far_q && room;

  // The absolute distance reaches the threshold when either side leads by it.
  assign ip_ext   = {1'b0, ip_q};
  assign prev_ext = {1'b0, prev_q};
  assign thr_ext  = {49'd0, jump_thr_q};
  assign far_d    = (ip_ext >= prev_ext + thr_ext) || (prev_ext >= ip_ext + thr_ext);

  // Saturating increment; an entry cleared by an emit restarts at one.
  assign inc_val = !valid_q[hit_idx_q] ? 32'd1 :
                   (cnt_rd_q == CountMax) ? cnt_rd_q : cnt_rd_q + 32'd1;

  assign cnt_raddr = cmd_i.inc_rd ? hit_idx_q : eptr_q;

  assign status_o.wrap      = wrap;
  assign status_o.any_valid = any_valid;
  assign status_o.emit_last = emit_last;
  assign status_o.hit       = cmp_v_q && (addr_rd_q == ip_q);
  assign status_o.miss_done = !cmp_v_q && !scan_more;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_len_q <= IntervalLengthReset;
      jump_thr_q     <= JumpThresholdReset;
      progress_q     <= '0;
      prev_q         <= '0;
      overflow_q     <= 1'b0;
      used_q         <= '0;
      valid_q        <= '0;
      eptr_q         <= '0;
      sptr_q         <= '0;
      cmp_v_q        <= 1'b0;
      res_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgIntervalLength: interval_len_q <= cfg_data_i;
          CfgJumpThreshold:  jump_thr_q     <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (cmd_i.accept && !req_i.func) begin
        progress_q <= wrap ? 32'd0 : progress_q + 32'd1;
      end

      // Pointers restart with every transaction.
      if (cmd_i.accept) begin
        eptr_q <= '0;
        sptr_q <= '0;
      end else begin
        if (cmd_i.emit && any_valid) begin
          eptr_q <= eptr_q + IdxW'(1);
        end
        if (cmd_i.search && scan_more) begin
          sptr_q <= sptr_q + CntW'(1);
        end
      end
      cmp_v_q <= cmd_i.search && scan_more;

      // Emit clears each entry as it is read; counting sets it again.
      if (cmd_i.emit && any_valid) begin
        valid_q[eptr_q] <= 1'b0;
      end
      if (cmd_i.inc_wr) begin
        valid_q[hit_idx_q] <= 1'b1;
      end
      if (add_block) begin
        valid_q[used_idx] <= 1'b1;
        used_q            <= used_q + CntW'(1);
      end
      if (cmd_i.newblk && far_q && !room) begin
        overflow_q <= 1'b1;
      end

      if (cmd_i.inc_wr || cmd_i.newblk) begin
        prev_q <= ip_q;
      end

      res_valid_q <= cmd_i.emit && (!any_valid || valid_q[eptr_q]);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ip_q <= req_i.ip;
    end
    far_q     <= far_d;
    cmp_idx_q <= sptr_idx;
    if (cmd_i.search && status_o.hit) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (cmd_i.emit) begin
      res_has_q  <= any_valid;
      res_id_q   <= eptr_q;
      res_full_q <= overflow_q;
      res_last_q <= !any_valid || emit_last;
    end
  end

  // Start-address memory: one scan read per cycle, written on a new block.
  always_ff @(posedge clk_i) begin
    if (cmd_i.search && scan_more) begin
      addr_rd_q <= addr_mem[sptr_idx];
    end
    if (add_block) begin
      addr_mem[used_idx] <= ip_q;
    end
  end

  // Count memory: read for emit or increment, written on increment or a new block.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit || cmd_i.inc_rd) begin
      cnt_rd_q <= cnt_mem[cnt_raddr];
    end
    if (cmd_i.inc_wr) begin
      cnt_mem[hit_idx_q] <= inc_val;
    end else if (add_block) begin
      cnt_mem[used_idx] <= 32'd1;
    end
  end

  // Result transaction.
  assign res_valid_o      = res_valid_q;
  assign res_o.has_entry  = res_has_q;
  assign res_o.block_id   = BlockIdW'(res_id_q);
  assign res_o.count      = res_has_q ? cnt_rd_q : 32'd0;
  assign res_o.table_full = res_full_q;
  assign res_o.last       = res_last_q;

endmodule
